[hdl/assert_macros.svh]
// assertion macros used by the port-level checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge while out of reset
`define VTPG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property checked on every clock edge, reset included
`define VTPG_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[hdl/vtpg_pkg.sv]
// types and constants of the video test pattern generator
// no dependencies
`timescale 1ns / 1ps

package vtpg_pkg;

    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int SIZE_W      = 11;
    localparam int RAMP_STEP_W = 24;
    localparam int DIAG_STEP_W = 26;
    localparam int RAMP_ACC_W  = 26;
    localparam int DIAG_ACC_W  = 27;
    localparam int CFG_W       = 26;
    localparam int CFG_IDX_W   = 2;
    localparam int CHROMA_W    = 8;

    localparam logic [CHROMA_W-1:0] LUMA_CONST = 8'h80;
    localparam logic [CHROMA_W-1:0] CHROMA_MAX = 8'hFF;

    localparam logic [SIZE_W-1:0]      RST_LINE_WIDTH    = 11'd720;
    localparam logic [SIZE_W-1:0]      RST_FRAME_HEIGHT  = 11'd288;
    localparam logic [RAMP_STEP_W-1:0] RST_RAMP_STEP     = 24'd23301;
    localparam logic [DIAG_STEP_W-1:0] RST_DIAGONAL_STEP = 26'd163840;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT  = 2'd1,
        CFG_RAMP_STEP     = 2'd2,
        CFG_DIAGONAL_STEP = 2'd3
    } t_cfg_index;

    // one pixel position with its accumulators, handed from raster to pattern stage
    typedef struct packed {
        logic [COL_W-1:0]      col;
        logic [ROW_W-1:0]      row;
        logic [RAMP_ACC_W-1:0] ramp_acc;
        logic [DIAG_ACC_W-1:0] diag_acc;
        logic                  last_col;
        logic                  last_row;
    } t_pixel;

endpackage

[hdl/vtpg_raster.sv]
// raster position counter and ramp/diagonal accumulators, registered pixel stage
// depends on vtpg_pkg
`timescale 1ns / 1ps

module vtpg_raster (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [vtpg_pkg::SIZE_W-1:0]          i_width,
    input  logic [vtpg_pkg::SIZE_W-1:0]          i_height,
    input  logic [vtpg_pkg::RAMP_STEP_W-1:0]     i_ramp_step,
    input  logic [vtpg_pkg::DIAG_STEP_W-1:0]     i_diag_step,
    input  logic                                 i_valid,
    input  logic                                 i_restart,
    output logic                                 o_ready,
    output logic                                 o_valid,
    output vtpg_pkg::t_pixel                     o_pixel,
    input  logic                                 i_ready
);

    localparam int RW = vtpg_pkg::RAMP_ACC_W;
    localparam int DW = vtpg_pkg::DIAG_ACC_W;
    localparam int SW = vtpg_pkg::SIZE_W;

    logic [vtpg_pkg::COL_W-1:0] r_col, n_col, cur_col;
    logic [vtpg_pkg::ROW_W-1:0] r_row, n_row, cur_row;
    logic [RW-1:0]              r_ramp, n_ramp, cur_ramp;
    logic [DW-1:0]              r_diag, n_diag, cur_diag;
    logic                       r_valid;
    vtpg_pkg::t_pixel           r_pixel;

    logic          accept;
    logic          last_col, last_row;
    logic [RW:0]   ramp_sum;
    logic [DW:0]   diag_sum;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        cur_col  = i_restart ? '0 : r_col;
        cur_row  = i_restart ? '0 : r_row;
        cur_ramp = i_restart ? '0 : r_ramp;
        cur_diag = i_restart ? '0 : r_diag;

        last_col = (SW'(cur_col) + SW'(1)) >= i_width;
        last_row = (SW'(cur_row) + SW'(1)) >= i_height;

        // saturating accumulation: the carry out marks overflow
        ramp_sum = {1'b0, cur_ramp} + (RW + 1)'(i_ramp_step);
        diag_sum = {1'b0, cur_diag} + (DW + 1)'(i_diag_step);

        n_col  = '0;
        n_row  = cur_row;
        n_ramp = '0;
        n_diag = cur_diag;
        if (!last_col) begin
            n_col  = cur_col + 1'b1;
            n_ramp = ramp_sum[RW] ? '1 : ramp_sum[RW-1:0];
        end else if (!last_row) begin
            n_row  = cur_row + 1'b1;
            n_diag = diag_sum[DW] ? '1 : diag_sum[DW-1:0];
        end else begin
            n_row  = '0;
            n_diag = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_ramp  <= '0;
            r_diag  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_ramp <= n_ramp;
                r_diag <= n_diag;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pixel.col      <= cur_col;
            r_pixel.row      <= cur_row;
            r_pixel.ramp_acc <= cur_ramp;
            r_pixel.diag_acc <= cur_diag;
            r_pixel.last_col <= last_col;
            r_pixel.last_row <= last_row;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

[hdl/vtpg_pattern.sv]
// chroma layering (ramp, diagonals, center lines) and the output register
// depends on vtpg_pkg
`timescale 1ns / 1ps

module vtpg_pattern #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [vtpg_pkg::SIZE_W-1:0]       i_width,
    input  logic [vtpg_pkg::SIZE_W-1:0]       i_height,
    input  logic                              i_valid,
    input  vtpg_pkg::t_pixel                  i_pixel,
    output logic                              o_ready,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [39:0]                       o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    localparam int SW   = vtpg_pkg::SIZE_W;
    localparam int RW   = vtpg_pkg::RAMP_ACC_W;
    localparam int DAW  = vtpg_pkg::DIAG_ACC_W;
    localparam int WQW  = SW + FRACTION_BITS;
    localparam int XW   = (WQW > DAW) ? WQW : DAW;
    localparam int CW   = vtpg_pkg::CHROMA_W;

    logic [RW-1:0]  ramp_int;
    logic [XW-1:0]  dacc, wq, x1, x2, col_x, width_x;
    logic [vtpg_pkg::ROW_W-1:0] row_m1;
    logic [CW-1:0]  dval, chroma;
    logic           hit1, hit2;

    logic           r_valid;
    logic [39:0]    r_data;
    logic           r_last;

    assign o_ready = !r_valid || i_m_axis_tready;

    always_comb begin
        ramp_int = i_pixel.ramp_acc >> FRACTION_BITS;
        chroma   = (ramp_int > RW'(vtpg_pkg::CHROMA_MAX)) ? vtpg_pkg::CHROMA_MAX
                                                         : ramp_int[CW-1:0];

        dacc    = XW'(i_pixel.diag_acc);
        wq      = XW'(i_width) << FRACTION_BITS;
        col_x   = XW'(i_pixel.col);
        width_x = XW'(i_width);
        x1      = dacc >> FRACTION_BITS;
        x2      = (wq - dacc) >> FRACTION_BITS;
        row_m1  = i_pixel.row - 1'b1;
        dval    = {row_m1[3:0], 4'h0};

        hit1 = (x1 == col_x) && (x1 < width_x);
        hit2 = (dacc <= wq) && (x2 == col_x) && (x2 < width_x);
        if ((i_pixel.row != '0) && (hit1 || hit2)) begin
            chroma = dval;
        end
        // center lines drawn last, vertical on top
        if (SW'(i_pixel.row) == (i_height >> 1)) begin
            chroma = {i_pixel.col[3:0], 4'h0};
        end
        if (SW'(i_pixel.col) == (i_width >> 1)) begin
            chroma = {i_pixel.row[3:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= {4'h0, vtpg_pkg::LUMA_CONST, chroma, i_pixel.row, i_pixel.col};
            r_last <= i_pixel.last_col && i_pixel.last_row;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;
    assign o_m_axis_tlast  = r_last;

endmodule

[hdl/video_test_pattern_generator.sv]
// top level of the video test pattern generator: config registers, raster, pattern
// depends on vtpg_pkg, vtpg_raster, vtpg_pattern
`timescale 1ns / 1ps

// Streams a test frame in raster order, one pixel per request on the slave side.
// Each input request carries a restart bit: 1 jumps back to pixel zero and emits it,
// 0 emits the next pixel. Throughput is one pixel per clock while the output is not
// held by back-pressure; a pixel passes the raster counter register and then the
// pattern output register. The chroma byte is a saturated horizontal ramp from a
// fixed-point accumulator, overlaid by two diagonals, a line on the middle row
// and a line on the middle column (last one wins). Luma is always 0x80 and tlast
// marks the last pixel of the frame. Width and height of zero count as one and are
// clamped to the maximum parameters. The user must write registers through the
// plain write port only while no pixel is in flight; the block does not enforce it.

module video_test_pattern_generator #(
    parameter int MAX_LINE_WIDTH   = 1024,
    parameter int MAX_FRAME_HEIGHT = 1024,
    parameter int FRACTION_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [vtpg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vtpg_pkg::CFG_W-1:0]          i_cfg_data,
    // input request stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [7:0]                          i_s_axis_tdata,  // [0] restart, [7:1] zero
    // pixel stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [39:0]                         o_m_axis_tdata,  // [9:0] column,
                                                                 // [19:10] row,
                                                                 // [27:20] chroma_value,
                                                                 // [35:28] luma_value,
                                                                 // [39:36] zero
    output logic                                o_m_axis_tlast   // end_of_frame
);

    localparam int SW = vtpg_pkg::SIZE_W;
    localparam logic [31:0] MAX_W32 = 32'(MAX_LINE_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_FRAME_HEIGHT);

    // configuration registers
    logic [SW-1:0]                        r_line_width;
    logic [SW-1:0]                        r_frame_height;
    logic [vtpg_pkg::RAMP_STEP_W-1:0]     r_ramp_step;
    logic [vtpg_pkg::DIAG_STEP_W-1:0]     r_diagonal_step;

    // effective frame size after the zero and maximum special cases
    logic [SW-1:0] eff_width, eff_height;

    // raster to pattern stage
    logic             pix_valid, pix_ready;
    vtpg_pkg::t_pixel pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= vtpg_pkg::RST_LINE_WIDTH;
            r_frame_height  <= vtpg_pkg::RST_FRAME_HEIGHT;
            r_ramp_step     <= vtpg_pkg::RST_RAMP_STEP;
            r_diagonal_step <= vtpg_pkg::RST_DIAGONAL_STEP;
        end else if (i_cfg_we) begin
            case (vtpg_pkg::t_cfg_index'(i_cfg_index))
                vtpg_pkg::CFG_LINE_WIDTH:    r_line_width    <= i_cfg_data[SW-1:0];
                vtpg_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[SW-1:0];
                vtpg_pkg::CFG_RAMP_STEP:
                    r_ramp_step <= i_cfg_data[vtpg_pkg::RAMP_STEP_W-1:0];
                vtpg_pkg::CFG_DIAGONAL_STEP:
                    r_diagonal_step <= i_cfg_data[vtpg_pkg::DIAG_STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_line_width == '0) begin
            eff_width = SW'(1);
        end else if (32'(r_line_width) > MAX_W32) begin
            eff_width = MAX_W32[SW-1:0];
        end else begin
            eff_width = r_line_width;
        end
        if (r_frame_height == '0) begin
            eff_height = SW'(1);
        end else if (32'(r_frame_height) > MAX_H32) begin
            eff_height = MAX_H32[SW-1:0];
        end else begin
            eff_height = r_frame_height;
        end
    end

    // position counters and accumulators
    vtpg_raster u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_width     (eff_width),
        .i_height    (eff_height),
        .i_ramp_step (r_ramp_step),
        .i_diag_step (r_diagonal_step),
        .i_valid     (i_s_axis_tvalid),
        .i_restart   (i_s_axis_tdata[0]),
        .o_ready     (o_s_axis_tready),
        .o_valid     (pix_valid),
        .o_pixel     (pixel),
        .i_ready     (pix_ready)
    );

    // chroma layering and output register
    vtpg_pattern #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pattern (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_width         (eff_width),
        .i_height        (eff_height),
        .i_valid         (pix_valid),
        .i_pixel         (pixel),
        .o_ready         (pix_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[hdl/vtpg_checker.sv]
// port-level checks on the video test pattern generator, bound to the top level
// depends on assert_macros.svh and video_test_pattern_generator
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vtpg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast
);

    // a stalled pixel keeps its value
    `VTPG_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))

    // luma field constant and padding zero on every pixel
    `VTPG_ASSERT(a_luma_const, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[39:28] == 12'h080))

    // with the output register empty the pipeline always takes a request
    `VTPG_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready)

    // reset empties the output side
    `VTPG_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind video_test_pattern_generator vtpg_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

[dv/vtpg_pixel_checker.sv]
// pixel checker for the video test pattern generator: keeps its own raster
// state, predicts each pixel from the requests and register writes it sees
// depends on vtpg_pkg
`timescale 1ns / 1ps

module vtpg_pixel_checker #(
    parameter int MAX_LINE_WIDTH   = 1024,
    parameter int MAX_FRAME_HEIGHT = 1024,
    parameter int FRACTION_BITS    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [vtpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vtpg_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    input  logic                           i_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // [0] restart, [7:1] zero
    input  logic                           i_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    input  logic [39:0]                    i_m_axis_tdata,  // [9:0] column, [19:10] row,
                                                            // [27:20] chroma, [35:28] luma
    input  logic                           i_m_axis_tlast,  // end_of_frame
    output int                             o_mismatches,
    output int                             o_outstanding
);

    localparam longint unsigned RAMP_SAT = (64'd1 << vtpg_pkg::RAMP_ACC_W) - 1;
    localparam longint unsigned DIAG_SAT = (64'd1 << vtpg_pkg::DIAG_ACC_W) - 1;

    typedef struct packed {
        logic [vtpg_pkg::COL_W-1:0]    col;
        logic [vtpg_pkg::ROW_W-1:0]    row;
        logic [vtpg_pkg::CHROMA_W-1:0] chroma;
        logic [vtpg_pkg::CHROMA_W-1:0] luma;
        logic                          eof;
    } t_pixel_out;

    // register copies
    logic [vtpg_pkg::SIZE_W-1:0]      line_width;
    logic [vtpg_pkg::SIZE_W-1:0]      frame_height;
    logic [vtpg_pkg::RAMP_STEP_W-1:0] ramp_step;
    logic [vtpg_pkg::DIAG_STEP_W-1:0] diag_step;

    // raster position and accumulators
    logic [vtpg_pkg::COL_W-1:0]      col_cnt;
    logic [vtpg_pkg::ROW_W-1:0]      row_cnt;
    logic [vtpg_pkg::RAMP_ACC_W-1:0] ramp_acc;
    logic [vtpg_pkg::DIAG_ACC_W-1:0] diag_acc;

    t_pixel_out pixels_due[$];
    int         mismatches;

    function automatic longint unsigned clamp_size(input longint unsigned v,
                                                   input longint unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic longint unsigned sat_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned maxv);
        longint unsigned s;
        s = a + b;
        return (s > maxv) ? maxv : s;
    endfunction

    // works out one pixel and advances the raster
    function automatic t_pixel_out predict_pixel(input logic restart);
        longint unsigned w, h, c, r, chroma, dval, x1, x2, wq;
        logic       last_col, last_row;
        t_pixel_out px;
        if (restart) begin
            col_cnt  = '0;
            row_cnt  = '0;
            ramp_acc = '0;
            diag_acc = '0;
        end
        w = clamp_size(line_width, MAX_LINE_WIDTH);
        h = clamp_size(frame_height, MAX_FRAME_HEIGHT);
        c = col_cnt;
        r = row_cnt;

        // ramp, integer part saturated
        chroma = ramp_acc >> FRACTION_BITS;
        if (chroma > vtpg_pkg::CHROMA_MAX) chroma = vtpg_pkg::CHROMA_MAX;

        // both diagonals, dropped when they fall outside the line
        if (r >= 1) begin
            dval = (16 * (r - 1)) & 8'hFF;
            x1 = diag_acc >> FRACTION_BITS;
            if (x1 == c && x1 < w) chroma = dval;
            wq = w << FRACTION_BITS;
            if (diag_acc <= wq) begin
                x2 = (wq - diag_acc) >> FRACTION_BITS;
                if (x2 == c && x2 < w) chroma = dval;
            end
        end

        // middle row, then middle column on top
        if (r == h / 2) chroma = (16 * c) & 8'hFF;
        if (c == w / 2) chroma = (16 * r) & 8'hFF;

        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);

        px.col    = vtpg_pkg::COL_W'(c);
        px.row    = vtpg_pkg::ROW_W'(r);
        px.chroma = vtpg_pkg::CHROMA_W'(chroma);
        px.luma   = vtpg_pkg::LUMA_CONST;
        px.eof    = last_col && last_row;

        if (!last_col) begin
            col_cnt  = vtpg_pkg::COL_W'(c + 1);
            ramp_acc = vtpg_pkg::RAMP_ACC_W'(sat_add(ramp_acc, ramp_step, RAMP_SAT));
        end else begin
            col_cnt  = '0;
            ramp_acc = '0;
            if (!last_row) begin
                row_cnt  = vtpg_pkg::ROW_W'(r + 1);
                diag_acc = vtpg_pkg::DIAG_ACC_W'(sat_add(diag_acc, diag_step, DIAG_SAT));
            end else begin
                row_cnt  = '0;
                diag_acc = '0;
            end
        end
        return px;
    endfunction

    task automatic check_field(input string name, input int unsigned due,
                               input int unsigned got);
        if (due != got) begin
            $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $time, name, due,
                     got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_pixel_out due;
        t_pixel_out got;
        if (!i_rst_n) begin
            line_width   = vtpg_pkg::RST_LINE_WIDTH;
            frame_height = vtpg_pkg::RST_FRAME_HEIGHT;
            ramp_step    = vtpg_pkg::RST_RAMP_STEP;
            diag_step    = vtpg_pkg::RST_DIAGONAL_STEP;
            col_cnt      = '0;
            row_cnt      = '0;
            ramp_acc     = '0;
            diag_acc     = '0;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (vtpg_pkg::t_cfg_index'(i_cfg_index))
                    vtpg_pkg::CFG_LINE_WIDTH:
                        line_width   = i_cfg_data[vtpg_pkg::SIZE_W-1:0];
                    vtpg_pkg::CFG_FRAME_HEIGHT:
                        frame_height = i_cfg_data[vtpg_pkg::SIZE_W-1:0];
                    vtpg_pkg::CFG_RAMP_STEP:
                        ramp_step    = i_cfg_data[vtpg_pkg::RAMP_STEP_W-1:0];
                    vtpg_pkg::CFG_DIAGONAL_STEP:
                        diag_step    = i_cfg_data[vtpg_pkg::DIAG_STEP_W-1:0];
                    default: ;
                endcase
            end

            // pixel leaving the block, compared with the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.col    = i_m_axis_tdata[9:0];
                got.row    = i_m_axis_tdata[19:10];
                got.chroma = i_m_axis_tdata[27:20];
                got.luma   = i_m_axis_tdata[35:28];
                got.eof    = i_m_axis_tlast;
                if (pixels_due.size() == 0) begin
                    $display("%0t: pixel with none expected, expected nothing, actual %p",
                             $time, got);
                    mismatches++;
                end else begin
                    due = pixels_due.pop_front();
                    check_field("column", due.col, got.col);
                    check_field("row", due.row, got.row);
                    check_field("chroma", due.chroma, got.chroma);
                    check_field("luma", due.luma, got.luma);
                    check_field("end_of_frame", due.eof, got.eof);
                end
            end

            if (i_s_axis_tvalid && i_s_axis_tready)
                pixels_due.push_back(predict_pixel(i_s_axis_tdata[0]));
        end
        o_outstanding <= pixels_due.size();
        o_mismatches  <= mismatches;
    end

endmodule

[dv/video_test_pattern_generator_tb.sv]
// testbench top for the video test pattern generator: clock, reset, requests,
// register writes, output back-pressure and the verdict
// depends on vtpg_pkg, video_test_pattern_generator, vtpg_pixel_checker
`timescale 1ns / 1ps

module video_test_pattern_generator_tb;

    localparam int MAX_W       = 1024;
    localparam int MAX_H       = 1024;
    localparam int FRAC        = 16;
    localparam int TOTAL_ITEMS = 1150;
    // longest legal silence is the forced output hold plus a few stall runs
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 64;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [vtpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [vtpg_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [39:0]                    m_tdata;
    logic                           m_tlast;

    int mismatches;
    int outstanding;
    int items_sent   = 0;
    int tx_idle_pct  = 0;  // only the request process reads this
    int rx_stall_pct = 0;  // written at the clock edge, read by the output process
    int hold_tag     = 0;  // bumped to ask the output process for a long hold
    int hold_seen    = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    video_test_pattern_generator #(
        .MAX_LINE_WIDTH  (MAX_W),
        .MAX_FRAME_HEIGHT(MAX_H),
        .FRACTION_BITS   (FRAC)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tlast (m_tlast)
    );

    vtpg_pixel_checker #(
        .MAX_LINE_WIDTH  (MAX_W),
        .MAX_FRAME_HEIGHT(MAX_H),
        .FRACTION_BITS   (FRAC)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_tvalid),
        .i_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .i_m_axis_tdata (m_tdata),
        .i_m_axis_tlast (m_tlast),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pixel sink: random stalls per phase, plus a long hold in the first phase
    // that lets the pipeline fill and push back on the request side
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_seen != hold_tag) begin
            hold_seen <= hold_tag;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: any accepted request or pixel counts as progress
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("video_test_pattern_generator_tb: errors");
                $finish;
            end
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 0;
            end
            IDLE_SENDER: begin
                tx_idle_pct = 84;
                rx_stall_pct <= 0;
            end
            IDLE_RECEIVER: begin
                tx_idle_pct = 0;
                rx_stall_pct <= 84;
            end
            default: begin
                tx_idle_pct = 10;
                rx_stall_pct <= 10;
            end
        endcase
    endtask

    // one request; tvalid stays up between back-to-back requests
    task automatic send_request(input logic restart);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // stop requesting and wait until every predicted pixel has come out;
    // the first edge lets the checker count the last accepted request
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // all four registers, back to back, only while the block is idle
    task automatic program_frame(input int unsigned w, input int unsigned h,
                                 input int unsigned ramp, input int unsigned diag);
        cfg_we    <= 1'b1;
        cfg_index <= vtpg_pkg::CFG_LINE_WIDTH;
        cfg_data  <= vtpg_pkg::CFG_W'(w);
        @(posedge clk);
        cfg_index <= vtpg_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= vtpg_pkg::CFG_W'(h);
        @(posedge clk);
        cfg_index <= vtpg_pkg::CFG_RAMP_STEP;
        cfg_data  <= vtpg_pkg::CFG_W'(ramp);
        @(posedge clk);
        cfg_index <= vtpg_pkg::CFG_DIAGONAL_STEP;
        cfg_data  <= vtpg_pkg::CFG_W'(diag);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly small frames so they wrap often; now and then zero, huge or
    // clamped sizes and off-nominal steps
    task automatic random_frame();
        int unsigned pick, w, h, weff, heff, ramp, diag;
        pick = $urandom_range(99);
        if (pick < 70)      w = $urandom_range(24, 1);
        else if (pick < 80) w = 0;
        else if (pick < 90) w = $urandom_range(1024, 25);
        else                w = $urandom_range(2047, 1025);
        pick = $urandom_range(99);
        if (pick < 70)      h = $urandom_range(16, 1);
        else if (pick < 80) h = 0;
        else if (pick < 90) h = $urandom_range(1024, 17);
        else                h = $urandom_range(2047, 1025);
        weff = (w == 0) ? 1 : ((w > MAX_W) ? MAX_W : w);
        heff = (h == 0) ? 1 : ((h > MAX_H) ? MAX_H : h);

        pick = $urandom_range(99);
        if (pick < 60) begin
            ramp = (256 << FRAC) / weff;
            if (ramp > 24'hFFFFFF) ramp = 24'hFFFFFF;
            ramp = ramp ^ $urandom_range(15);
        end else if (pick < 75) ramp = 0;
        else if (pick < 90)     ramp = 24'hFFFFFF;
        else                    ramp = $urandom_range(24'hFFFFFF);

        pick = $urandom_range(99);
        if (pick < 60) begin
            diag = (weff << FRAC) / heff;
            if (diag > 26'h3FFFFFF) diag = 26'h3FFFFFF;
            diag = diag ^ $urandom_range(15);
        end else if (pick < 75) diag = 0;
        else if (pick < 85)     diag = 26'h3FFFFFF;
        else                    diag = $urandom_range(26'h3FFFFFF);

        program_frame(w, h, ramp, diag);
    endtask

    initial begin : stimulus
        int phase;
        int count;
        int restart_pct;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(IDLE_NONE);

        // reset setting: first pixels of the 720x288 frame, restart included
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        drain();

        // zero sizes count as one: every pixel ends the frame
        program_frame(0, 0, vtpg_pkg::RST_RAMP_STEP, vtpg_pkg::RST_DIAGONAL_STEP);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // tiny frame with full-scale steps: the ramp chroma and the diagonal
        // accumulator saturate and the diagonals run off the line
        program_frame(3, 4, 24'hFFFFFF, 26'h3FFFFFF);
        send_request(1'b1);
        repeat (11) send_request(1'b0);
        drain();

        // sizes past the maximum clamp, zero steps
        program_frame(2047, 2047, 0, 0);
        send_request(1'b1);
        repeat (3) send_request(1'b0);
        drain();

        // line shrunk under the current column: it closes the line at once
        program_frame(2, 2047, 0, 0);
        send_request(1'b0);
        send_request(1'b0);
        drain();

        // random phases; the first one holds the sink off for a long while
        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (phase == 0) begin
                set_idling(IDLE_NONE);
                hold_tag <= hold_tag + 1;
            end else begin
                set_idling(t_idle_mode'(phase % 4));
            end
            if (phase == 0 || $urandom_range(3) != 0) random_frame();
            count       = $urandom_range(70, 20);
            restart_pct = ($urandom_range(3) == 0) ? 20 : 2;
            repeat (count) send_request($urandom_range(99) < restart_pct);
            drain();
            phase++;
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("video_test_pattern_generator_tb: clean");
        end else begin
            $display("video_test_pattern_generator_tb: errors");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/vtpg_pkg.sv
hdl/vtpg_raster.sv
hdl/vtpg_pattern.sv
hdl/video_test_pattern_generator.sv
hdl/vtpg_checker.sv
dv/vtpg_pixel_checker.sv
dv/video_test_pattern_generator_tb.sv
